// ===== sv/esc_pkg.sv =====
`default_nettype none
package esc_pkg;

  typedef struct packed {
    logic [19:0] adc_temperature;
    logic [19:0] adc_pressure;
    logic [15:0] adc_humidity;
  } in_t;

  typedef struct packed {
    logic [31:0] temperature_centi;
    logic [31:0] pressure_pa;
    logic [16:0] humidity_q10;
  } out_t;

  // sideband carried alongside the divider
  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        dbl;   // quotient needs doubling
    logic        zero;  // divisor was zero
  } div_side_t;

  localparam int unsigned DIV_W = 32;

  // register indexes
  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_PRESS_C = 3'd3;
  localparam logic [2:0] REG_HUM     = 3'd4;

  localparam logic [31:0] P_OFS      = 32'd64000;
  localparam logic [31:0] P_ONE      = 32'd32768;
  localparam logic [31:0] P_FULL     = 32'd1048576;
  localparam logic [31:0] P_SCALE    = 32'd3125;
  localparam logic [31:0] SIGN32     = 32'h8000_0000;
  localparam logic [31:0] H_OFS      = 32'd76800;
  localparam logic [31:0] H_RND      = 32'd16384;
  localparam logic [31:0] H_INNER    = 32'd32768;
  localparam logic [31:0] H_BIAS     = 32'd2097152;
  localparam logic [31:0] H_RND2     = 32'd8192;
  localparam logic [31:0] H_MAX      = 32'd419430400;
  localparam logic [31:0] T_RND      = 32'd128;
  localparam logic [31:0] T_MUL      = 32'd5;

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] s);
    return $unsigned($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== sv/esc_div.sv =====
`default_nettype none
// Restoring unsigned divider, one quotient bit per stage.
module esc_div #(
  parameter int unsigned DivW  = esc_pkg::DIV_W,
  parameter int unsigned SideW = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [DivW-1:0]   dividend_i,
  input  wire logic [DivW-1:0]   divisor_i,
  input  wire logic [SideW-1:0]  side_i,
  output logic                   valid_o,
  output logic [DivW-1:0]        quot_o,
  output logic [SideW-1:0]       side_o
);

  logic [DivW-1:0]  vld_q;
  logic [DivW:0]    rem_q [DivW];
  logic [DivW-1:0]  num_q [DivW];
  logic [DivW-1:0]  den_q [DivW];
  logic [SideW-1:0] side_q [DivW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivW-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < DivW; k++) begin : g_stage
    logic [DivW:0]    rem_in;
    logic [DivW-1:0]  num_in;
    logic [DivW-1:0]  den_in;
    logic [SideW-1:0] side_in;
    logic [DivW:0]    rem2;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign num_in  = dividend_i;
      assign den_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign num_in  = num_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rem2 = {rem_in[DivW-1:0], num_in[DivW-1]};
    assign ge   = rem2 >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem2 - {1'b0, den_in}) : rem2;
        num_q[k]  <= {num_in[DivW-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[DivW-1];
  assign quot_o  = num_q[DivW-1];
  assign side_o  = side_q[DivW-1];

endmodule
`default_nettype wire

// ===== sv/env_sensor_compensation.sv =====
// Pipeline: 14 front stages, 32 divider stages, 4 back stages including the
//   output register; the one-bit-per-stage divider makes up most of them.
// Throughput: one request per cycle; the whole pipe advances unless the
//   output holds a result that is stalled.
// Reset: asynchronous active low; clears valid bits and calibration registers.
`default_nettype none
module env_sensor_compensation (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire esc_pkg::in_t  in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output esc_pkg::out_t      out_rsp_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [5:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int unsigned FS = 14;   // front stages
  localparam int unsigned BS = 4;    // back stages

  // ---------------- configuration ----------------
  logic [47:0] tcal_q;
  logic [63:0] pcal_a_q, pcal_b_q, hcal_q;
  logic [15:0] pcal_c_q;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q   <= '0;
      pcal_a_q <= '0;
      pcal_b_q <= '0;
      pcal_c_q <= '0;
      hcal_q   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        esc_pkg::REG_TEMP:    tcal_q   <= pwdata[47:0];
        esc_pkg::REG_PRESS_A: pcal_a_q <= pwdata;
        esc_pkg::REG_PRESS_B: pcal_b_q <= pwdata;
        esc_pkg::REG_PRESS_C: pcal_c_q <= pwdata[15:0];
        esc_pkg::REG_HUM:     hcal_q   <= pwdata;
        default: ;  // unmapped, dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      esc_pkg::REG_TEMP:    prdata = {16'b0, tcal_q};
      esc_pkg::REG_PRESS_A: prdata = pcal_a_q;
      esc_pkg::REG_PRESS_B: prdata = pcal_b_q;
      esc_pkg::REG_PRESS_C: prdata = {48'b0, pcal_c_q};
      esc_pkg::REG_HUM:     prdata = hcal_q;
      default:              prdata = '0;
    endcase
  end

  // decoded coefficients, all sign/zero extended to 32 bits
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  assign t1 = {16'b0, tcal_q[15:0]};
  assign t2 = esc_pkg::sx16(tcal_q[31:16]);
  assign t3 = esc_pkg::sx16(tcal_q[47:32]);
  assign p1 = {16'b0, pcal_a_q[15:0]};
  assign p2 = esc_pkg::sx16(pcal_a_q[31:16]);
  assign p3 = esc_pkg::sx16(pcal_a_q[47:32]);
  assign p4 = esc_pkg::sx16(pcal_a_q[63:48]);
  assign p5 = esc_pkg::sx16(pcal_b_q[15:0]);
  assign p6 = esc_pkg::sx16(pcal_b_q[31:16]);
  assign p7 = esc_pkg::sx16(pcal_b_q[47:32]);
  assign p8 = esc_pkg::sx16(pcal_b_q[63:48]);
  assign p9 = esc_pkg::sx16(pcal_c_q);
  assign h1 = {24'b0, hcal_q[7:0]};
  assign h2 = esc_pkg::sx16(hcal_q[23:8]);
  assign h3 = {24'b0, hcal_q[31:24]};
  assign h4 = {20'b0, hcal_q[43:32]};
  assign h5 = {20'b0, hcal_q[55:44]};
  assign h6 = esc_pkg::sx8(hcal_q[63:56]);

  // ---------------- flow control ----------------
  // Single global enable: everything moves unless the output is held.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic [FS-1:0] fv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (adv) begin
      fv_q <= {fv_q[FS-2:0], in_valid_i};
    end
  end

  // ---------------- front stages ----------------
  logic [31:0] s1_ta, s1_d, s2_ma, s2_dd, s3_a, s3_b3, s4_fine;
  logic [19:0] s1_adcp, s2_adcp, s3_adcp, s4_adcp, s5_adcp, s6_adcp, s7_adcp, s8_adcp;
  logic [15:0] s1_adch, s2_adch, s3_adch, s4_adch, s5_adch, s6_adch;
  logic [31:0] s5_t5, s5_pa, s5_q, s5_x;
  logic [31:0] s6_temp, s6_qq, s6_pa5, s6_pa2, s6_xh5, s6_xh3, s6_xh6;
  logic [31:0] s7_temp, s7_b, s7_c3, s7_pa5, s7_pa2, s7_left, s7_inner, s7_r6;
  logic [31:0] s8_temp, s8_b, s8_a, s8_left, s8_r7;
  logic [31:0] s9_temp, s9_am, s9_pnum, s9_r8, s9_left;
  logic [31:0] s10_temp, s10_a, s10_p, s10_right, s10_left;
  logic [31:0] s11_temp, s11_y, s11_a, s11_p;
  logic [31:0] s12_temp, s12_y, s12_sq2, s12_a, s12_p;
  logic [31:0] s13_temp, s13_y, s13_m, s13_a, s13_p;
  logic [31:0] s14_dvd, s14_dvs;
  esc_pkg::div_side_t s14_side;
  logic [31:0] y_fin;

  always_comb begin
    y_fin = s13_y - esc_pkg::asr(s13_m, 5'd4);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // S1: temperature differences
      s1_ta   <= {15'b0, in_req_i.adc_temperature[19:3]} - {t1[30:0], 1'b0};
      s1_d    <= {16'b0, in_req_i.adc_temperature[19:4]} - t1;
      s1_adcp <= in_req_i.adc_pressure;
      s1_adch <= in_req_i.adc_humidity;
      // S2
      s2_ma   <= s1_ta * t2;
      s2_dd   <= s1_d * s1_d;
      s2_adcp <= s1_adcp;
      s2_adch <= s1_adch;
      // S3
      s3_a    <= esc_pkg::asr(s2_ma, 5'd11);
      s3_b3   <= esc_pkg::asr(s2_dd, 5'd12) * t3;
      s3_adcp <= s2_adcp;
      s3_adch <= s2_adch;
      // S4: fine temperature
      s4_fine <= s3_a + esc_pkg::asr(s3_b3, 5'd14);
      s4_adcp <= s3_adcp;
      s4_adch <= s3_adch;
      // S5
      s5_t5   <= s4_fine * esc_pkg::T_MUL + esc_pkg::T_RND;
      s5_pa   <= esc_pkg::asr(s4_fine, 5'd1) - esc_pkg::P_OFS;
      s5_q    <= esc_pkg::asr(esc_pkg::asr(s4_fine, 5'd1) - esc_pkg::P_OFS, 5'd2);
      s5_x    <= s4_fine - esc_pkg::H_OFS;
      s5_adcp <= s4_adcp;
      s5_adch <= s4_adch;
      // S6: products on fine
      s6_temp <= esc_pkg::asr(s5_t5, 5'd8);
      s6_qq   <= s5_q * s5_q;
      s6_pa5  <= s5_pa * p5;
      s6_pa2  <= p2 * s5_pa;
      s6_xh5  <= h5 * s5_x;
      s6_xh3  <= s5_x * h3;
      s6_xh6  <= s5_x * h6;
      s6_adcp <= s5_adcp;
      s6_adch <= s5_adch;
      // S7
      s7_temp  <= s6_temp;
      s7_b     <= esc_pkg::asr(s6_qq, 5'd11) * p6;
      s7_c3    <= p3 * esc_pkg::asr(s6_qq, 5'd13);
      s7_pa5   <= s6_pa5;
      s7_pa2   <= s6_pa2;
      s7_left  <= esc_pkg::asr(({2'b0, s6_adch, 14'b0} - {h4[11:0], 20'b0} - s6_xh5)
                               + esc_pkg::H_RND, 5'd15);
      s7_inner <= esc_pkg::asr(s6_xh3, 5'd11) + esc_pkg::H_INNER;
      s7_r6    <= esc_pkg::asr(s6_xh6, 5'd10);
      s7_adcp  <= s6_adcp;
      // S8
      s8_temp <= s7_temp;
      s8_b    <= esc_pkg::asr(s7_b + {s7_pa5[30:0], 1'b0}, 5'd2) + {p4[15:0], 16'b0};
      s8_a    <= esc_pkg::asr(esc_pkg::asr(s7_c3, 5'd3) + esc_pkg::asr(s7_pa2, 5'd1), 5'd18);
      s8_left <= s7_left;
      s8_r7   <= s7_r6 * s7_inner;
      s8_adcp <= s7_adcp;
      // S9
      s9_temp <= s8_temp;
      s9_am   <= (esc_pkg::P_ONE + s8_a) * p1;
      s9_pnum <= ((esc_pkg::P_FULL - {12'b0, s8_adcp}) - esc_pkg::asr(s8_b, 5'd12))
                 * esc_pkg::P_SCALE;
      s9_r8   <= (esc_pkg::asr(s8_r7, 5'd10) + esc_pkg::H_BIAS) * h2 + esc_pkg::H_RND2;
      s9_left <= s8_left;
      // S10
      s10_temp  <= s9_temp;
      s10_a     <= esc_pkg::asr(s9_am, 5'd15);
      s10_p     <= s9_pnum;
      s10_right <= esc_pkg::asr(s9_r8, 5'd14);
      s10_left  <= s9_left;
      // S11
      s11_temp <= s10_temp;
      s11_y    <= s10_left * s10_right;
      s11_a    <= s10_a;
      s11_p    <= s10_p;
      // S12
      s12_temp <= s11_temp;
      s12_y    <= s11_y;
      s12_sq2  <= esc_pkg::asr(s11_y, 5'd15) * esc_pkg::asr(s11_y, 5'd15);
      s12_a    <= s11_a;
      s12_p    <= s11_p;
      // S13
      s13_temp <= s12_temp;
      s13_y    <= s12_y;
      s13_m    <= esc_pkg::asr(s12_sq2, 5'd7) * h1;
      s13_a    <= s12_a;
      s13_p    <= s12_p;
      // S14: humidity clamp, divider operands
      s14_side.temp <= s13_temp;
      if (y_fin[31]) begin
        s14_side.hum <= '0;
      end else if (y_fin > esc_pkg::H_MAX) begin
        s14_side.hum <= esc_pkg::H_MAX[28:12];
      end else begin
        s14_side.hum <= y_fin[28:12];
      end
      s14_side.dbl  <= s13_p[31];
      s14_side.zero <= (s13_a == '0);
      s14_dvd       <= s13_p[31] ? s13_p : {s13_p[30:0], 1'b0};
      s14_dvs       <= s13_a;
    end
  end

  // ---------------- divider ----------------
  logic               dv_valid;
  logic [31:0]        dv_quot;
  esc_pkg::div_side_t dv_side;

  esc_div #(
    .DivW  (esc_pkg::DIV_W),
    .SideW ($bits(esc_pkg::div_side_t))
  ) u_div (
    .clk_i,
    .rst_ni,
    .en_i       (adv),
    .valid_i    (fv_q[FS-1]),
    .dividend_i (s14_dvd),
    .divisor_i  (s14_dvs),
    .side_i     (s14_side),
    .valid_o    (dv_valid),
    .quot_o     (dv_quot),
    .side_o     (dv_side)
  );

  // ---------------- back stages ----------------
  logic [BS-1:0] bv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else if (adv) begin
      bv_q <= {bv_q[BS-2:0], dv_valid};
    end
  end

  logic [31:0] b1_p, b2_p, b2_pp, b2_pb, b3_p, b3_a, b3_b;
  esc_pkg::div_side_t b1_s, b2_s, b3_s;
  esc_pkg::out_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_p  <= dv_side.dbl ? {dv_quot[30:0], 1'b0} : dv_quot;
      b1_s  <= dv_side;
      b2_pp <= {3'b0, b1_p[31:3]} * {3'b0, b1_p[31:3]};
      b2_pb <= {2'b0, b1_p[31:2]} * p8;
      b2_p  <= b1_p;
      b2_s  <= b1_s;
      b3_a  <= esc_pkg::asr(p9 * {13'b0, b2_pp[31:13]}, 5'd12);
      b3_b  <= esc_pkg::asr(b2_pb, 5'd13);
      b3_p  <= b2_p;
      b3_s  <= b2_s;
      out_q.temperature_centi <= b3_s.temp;
      out_q.humidity_q10      <= b3_s.hum;
      out_q.pressure_pa       <= b3_s.zero ? '0
                                 : b3_p + esc_pkg::asr(b3_a + b3_b + p7, 5'd4);
    end
  end

  assign out_valid_o = bv_q[BS-1];
  assign out_rsp_o   = out_q;

  // ---------------- checks ----------------
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.humidity_q10 <= 17'd102400)
    else $error("humidity out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_div_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && dv_valid |=> bv_q[0])
    else $error("divider result lost");

endmodule
`default_nettype wire
